// ===== design/i2a_pkg.sv =====
// Shared types, codes and the digit table for the integer to ASCII formatter.
// No dependencies; the design files but i2a_checker import this package.
`timescale 1ns / 1ps

package i2a_pkg;

   localparam logic [1:0] KIND_SDEC = 2'd0;
   localparam logic [1:0] KIND_UDEC = 2'd1;
   localparam logic [1:0] KIND_HEX  = 2'd2;
   localparam logic [1:0] KIND_BAD  = 2'd3;

   localparam int NUM_DIGITS     = 10;
   localparam int DABBLE_STAGES  = 4;
   localparam int BITS_PER_STAGE = 8;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;

   typedef struct packed {
      logic [1:0]  kind;
      logic        neg;
      logic [31:0] bin;
      logic [39:0] bcd;
   } conv_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d);
      logic [7:0] c;
      case (d)
         4'h0: c = 8'h30;
         4'h1: c = 8'h31;
         4'h2: c = 8'h32;
         4'h3: c = 8'h33;
         4'h4: c = 8'h34;
         4'h5: c = 8'h35;
         4'h6: c = 8'h36;
         4'h7: c = 8'h37;
         4'h8: c = 8'h38;
         4'h9: c = 8'h39;
         4'hA: c = 8'h41;
         4'hB: c = 8'h42;
         4'hC: c = 8'h43;
         4'hD: c = 8'h44;
         4'hE: c = 8'h45;
         default: c = 8'h46;
      endcase
      return c;
   endfunction

endpackage

// ===== design/integer_to_ascii_formatter.sv =====
// The pipeline stages and the serializer lead to the output register; characters
// follow one per cycle. A request produces 1 to 11 characters, and the serializer
// takes the next request as it picks the last character of the current one. Six
// pipeline stages hold requests while the serializer drains; busy is raised when
// the first stage cannot advance. The receiver cannot stall. Synchronous reset
// clears all valid bits and the serializer; the block is ready at once.
`timescale 1ns / 1ps

module integer_to_ascii_formatter import i2a_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_last
);

   conv_type                   pipe [0:DABBLE_STAGES];
   logic [DABBLE_STAGES:0]     pipe_v;
   logic [DABBLE_STAGES+1:0]   pipe_rdy;

   logic     s0_v_ff;
   conv_type s0_ff;
   conv_type s0_in;
   logic     neg;

   always_comb begin
      neg        = (req_action == KIND_SDEC) && req_value[31];
      s0_in.kind = req_action;
      s0_in.neg  = neg;
      s0_in.bin  = neg ? (32'd0 - req_value) : req_value;
      s0_in.bcd  = 40'd0;
   end

   assign pipe_rdy[0] = !s0_v_ff || pipe_rdy[1];
   assign busy        = !pipe_rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (pipe_rdy[0]) begin
         s0_v_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_rdy[0]) begin
         s0_ff <= s0_in;
      end
   end

   assign pipe_v[0] = s0_v_ff;
   assign pipe[0]   = s0_ff;

   for (genvar i = 1; i <= DABBLE_STAGES; i++) begin : g_dabble
      i2a_dabble u_dabble (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (pipe_v[i-1]),
         .in_data    (pipe[i-1]),
         .next_ready (pipe_rdy[i+1]),
         .ready      (pipe_rdy[i]),
         .out_valid  (pipe_v[i]),
         .out_data   (pipe[i])
      );
   end

   i2a_emit u_emit (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (pipe_v[DABBLE_STAGES]),
      .in_data      (pipe[DABBLE_STAGES]),
      .ready        (pipe_rdy[DABBLE_STAGES+1]),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

endmodule

// ===== design/i2a_dabble.sv =====
// One registered double-dabble stage: eight shift-and-adjust steps, none on hex.
// Depends on i2a_pkg for conv_type and the kind codes.
`timescale 1ns / 1ps

module i2a_dabble import i2a_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  conv_type in_data,
   input  logic     next_ready,
   output logic     ready,
   output logic     out_valid,
   output conv_type out_data
);

   logic     valid_ff;
   conv_type data_ff;
   conv_type data_in;
   logic [39:0] bcd;
   logic [31:0] bin;

   always_comb begin
      bcd = in_data.bcd;
      bin = in_data.bin;
      if (in_data.kind != KIND_HEX) begin
         for (int s = 0; s < BITS_PER_STAGE; s++) begin
            for (int d = 0; d < NUM_DIGITS; d++) begin
               if (bcd[d*4 +: 4] >= 4'd5) begin
                  bcd[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
               end
            end
            {bcd, bin} = {bcd[38:0], bin, 1'b0};
         end
      end
      data_in      = in_data;
      data_in.bcd  = bcd;
      data_in.bin  = bin;
   end

   assign ready = !valid_ff || next_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== design/i2a_emit.sv =====
// Leading-digit search stage and the character serializer with its output register.
// Depends on i2a_pkg for conv_type, kind codes, character codes and digit_char.
`timescale 1ns / 1ps

module i2a_emit import i2a_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  conv_type   in_data,
   output logic       ready,
   output logic       rsp_valid,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last
);

   logic [39:0] digits_in;
   logic [3:0]  msd_in;
   logic [1:0]  npre_in;
   logic [3:0]  len_in;

   logic        s5_v_ff;
   logic [1:0]  s5_kind_ff;
   logic [39:0] s5_digits_ff;
   logic [3:0]  s5_msd_ff;
   logic [1:0]  s5_npre_ff;
   logic [3:0]  s5_len_ff;

   logic        busy_ff;
   logic [3:0]  step_ff;
   logic [1:0]  kind_ff;
   logic [39:0] digits_ff;
   logic [3:0]  msd_ff;
   logic [1:0]  npre_ff;
   logic [3:0]  len_ff;

   logic        rsp_valid_ff;
   logic [7:0]  rsp_char_ff;
   logic        rsp_last_ff;

   logic        cur_last;
   logic        take;
   logic [3:0]  dstep;
   logic [3:0]  idx;
   logic [3:0]  nib;
   logic [7:0]  char_in;

   // Find the most significant nonzero digit, the prefix length and the length
   always_comb begin
      digits_in = (in_data.kind == KIND_HEX) ? {8'd0, in_data.bin} : in_data.bcd;
      msd_in = 4'd0;
      for (int d = 1; d < NUM_DIGITS; d++) begin
         if (digits_in[d*4 +: 4] != 4'd0) begin
            msd_in = 4'(d);
         end
      end
      case (in_data.kind)
         KIND_SDEC: npre_in = in_data.neg ? 2'd1 : 2'd0;
         KIND_UDEC: npre_in = 2'd0;
         KIND_HEX:  npre_in = 2'd2;
         default:   npre_in = 2'd1;
      endcase
      if (in_data.kind == KIND_BAD) begin
         len_in = 4'd1;
      end else begin
         len_in = {2'd0, npre_in} + msd_in + 4'd1;
      end
   end

   assign cur_last = (step_ff == len_ff - 4'd1);
   assign take     = !busy_ff || cur_last;
   assign ready    = !s5_v_ff || take;

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (ready) begin
         s5_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready) begin
         s5_kind_ff   <= in_data.kind;
         s5_digits_ff <= digits_in;
         s5_msd_ff    <= msd_in;
         s5_npre_ff   <= npre_in;
         s5_len_ff    <= len_in;
      end
   end

   // Pick the character for the current step
   always_comb begin
      dstep = step_ff - {2'd0, npre_ff};
      idx   = msd_ff - dstep;
      case (idx)
         4'd0: nib = digits_ff[3:0];
         4'd1: nib = digits_ff[7:4];
         4'd2: nib = digits_ff[11:8];
         4'd3: nib = digits_ff[15:12];
         4'd4: nib = digits_ff[19:16];
         4'd5: nib = digits_ff[23:20];
         4'd6: nib = digits_ff[27:24];
         4'd7: nib = digits_ff[31:28];
         4'd8: nib = digits_ff[35:32];
         4'd9: nib = digits_ff[39:36];
         default: nib = 4'd0;
      endcase
      if (step_ff < {2'd0, npre_ff}) begin
         case (kind_ff)
            KIND_HEX:  char_in = (step_ff == 4'd0) ? CHAR_ZERO : CHAR_X;
            KIND_SDEC: char_in = CHAR_MINUS;
            default:   char_in = CHAR_QUERY;
         endcase
      end else begin
         char_in = digit_char(nib);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= 4'd0;
      end else if (take && s5_v_ff) begin
         busy_ff <= 1'b1;
         step_ff <= 4'd0;
      end else if (busy_ff) begin
         busy_ff <= !cur_last;
         step_ff <= step_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (take && s5_v_ff) begin
         kind_ff   <= s5_kind_ff;
         digits_ff <= s5_digits_ff;
         msd_ff    <= s5_msd_ff;
         npre_ff   <= s5_npre_ff;
         len_ff    <= s5_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= busy_ff;
         rsp_last_ff  <= busy_ff && cur_last;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= char_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// ===== design/i2a_checker.sv =====
// Port-level checks for the integer to ASCII formatter, bound to the top level.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module i2a_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic [7:0]  rsp_char_out,
   input logic        rsp_last
);

   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response strobe right after reset");

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid)
      else $error("last without a response");

   a_prefix_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_char_out == 8'h2D || rsp_char_out == 8'h78)) |-> !rsp_last)
      else $error("sign or hex prefix ends a request");

   a_x_after_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_out == 8'h78) |->
         ($past(rsp_valid) && $past(rsp_char_out) == 8'h30 && !$past(rsp_last)))
      else $error("hex prefix not preceded by zero");

   a_query_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_char_out == 8'h3F) |-> rsp_last)
      else $error("unknown kind marker is not the only character");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_char_out (rsp_char_out),
   .rsp_last     (rsp_last)
);

// ===== tb/integer_to_ascii_formatter_test.sv =====
// Self-checking testbench for integer_to_ascii_formatter: directed and random requests,
// a scoreboard that predicts every output character, and checks of each rsp_ strobe.
// Depends on i2a_pkg and the integer_to_ascii_formatter RTL.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_test import i2a_pkg::*;;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam logic [7:0] LETTER_BASE = 8'h37;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } ascii_char_type;

   class ascii_scoreboard;
      ascii_char_type pending_chars[$];
      int requests_noted;
      int chars_checked;
      int errors;
      int kind_count[4];

      function void append_digits(ref logic [7:0] text[$], input logic [31:0] mag,
                                  input int unsigned radix);
         logic [7:0] digs[$];
         logic [31:0] rest;
         logic [3:0] d;
         rest = mag;
         do begin
            d = 4'(rest % radix);
            digs.push_front(d < 10 ? CHAR_ZERO + 8'(d) : LETTER_BASE + 8'(d));
            rest = rest / radix;
         end while (rest != 0);
         foreach (digs[i]) text.push_back(digs[i]);
      endfunction

      function void note_request(logic [1:0] action, logic [31:0] value);
         logic [7:0] text[$];
         logic [31:0] mag;
         ascii_char_type c;
         case (action)
            KIND_SDEC: begin
               mag = value;
               if (value[31]) begin
                  text.push_back(CHAR_MINUS);
                  mag = 32'd0 - value;
               end
               append_digits(text, mag, 10);
            end
            KIND_UDEC: append_digits(text, value, 10);
            KIND_HEX: begin
               text.push_back(CHAR_ZERO);
               text.push_back(CHAR_X);
               append_digits(text, value, 16);
            end
            default: text.push_back(CHAR_QUERY);
         endcase
         foreach (text[i]) begin
            c.code = text[i];
            c.last = (i == text.size() - 1);
            pending_chars.push_back(c);
         end
         requests_noted++;
         kind_count[action]++;
      endfunction

      function void check_char(logic [7:0] code, logic last);
         ascii_char_type want;
         chars_checked++;
         if (pending_chars.size() == 0) begin
            $display("%0t: unexpected char: expected none, got %h last %b", $realtime, code,
                     last);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (code !== want.code) begin
            $display("%0t: char_out mismatch: expected %h, got %h", $realtime, want.code, code);
            errors++;
         end
         if (last !== want.last) begin
            $display("%0t: last mismatch: expected %b, got %b", $realtime, want.last, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_action;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [7:0]  rsp_char_out;
   logic        rsp_last;

   ascii_scoreboard sb;
   int cycles;

   integer_to_ascii_formatter uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_action   (req_action),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d chars outstanding", $realtime, cycles,
                  sb.pending_chars.size());
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) sb.note_request(req_action, req_value);
      if (!reset && rsp_valid) sb.check_char(rsp_char_out, rsp_last);
   end

   task automatic send_request(logic [1:0] action, logic [31:0] value);
      @(negedge clock);
      start = 1'b1;
      req_action = action;
      req_value = value;
      do @(posedge clock); while (busy);
   endtask

   task automatic hold_idle(int n);
      @(negedge clock);
      start = 1'b0;
      req_action = 2'($urandom);
      req_value = $urandom;
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic logic [1:0] pick_action();
      case ($urandom_range(0, 9))
         0, 1, 2: return KIND_SDEC;
         3, 4, 5: return KIND_UDEC;
         6, 7, 8: return KIND_HEX;
         default: return KIND_BAD;
      endcase
   endfunction

   function automatic logic [31:0] pick_value();
      int unsigned p;
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 99);
         2: begin
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            return p + $urandom_range(0, 2) - 1;
         end
         3: return 32'd0 - $urandom_range(1, 1000);
         4: return $urandom >> $urandom_range(0, 31);
         default: return 32'h8000_0000 + $urandom_range(0, 15);
      endcase
   endfunction

   task automatic run_phase(int count, int idle_pct);
      repeat (count) begin
         send_request(pick_action(), pick_value());
         if ($urandom_range(1, 100) <= idle_pct) hold_idle($urandom_range(1, 8));
      end
   endtask

   initial begin
      sb = new();
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_action = KIND_SDEC;
      req_value = 32'd0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_request(KIND_SDEC, 32'd0);
      send_request(KIND_UDEC, 32'd0);
      send_request(KIND_HEX, 32'd0);
      send_request(KIND_SDEC, 32'h8000_0000);
      send_request(KIND_SDEC, 32'h7FFF_FFFF);
      send_request(KIND_SDEC, 32'hFFFF_FFFF);
      send_request(KIND_SDEC, 32'hFFFF_FFF6);
      send_request(KIND_UDEC, 32'hFFFF_FFFF);
      send_request(KIND_HEX, 32'hFFFF_FFFF);
      send_request(KIND_UDEC, 32'd1);
      send_request(KIND_UDEC, 32'd9);
      send_request(KIND_UDEC, 32'd10);
      send_request(KIND_SDEC, 32'd99);
      send_request(KIND_SDEC, 32'd100);
      send_request(KIND_UDEC, 32'd1000000000);
      send_request(KIND_UDEC, 32'd999999999);
      send_request(KIND_HEX, 32'h0000_000F);
      send_request(KIND_HEX, 32'h0000_0010);
      send_request(KIND_HEX, 32'hDEAD_BEEF);
      send_request(KIND_HEX, 32'h8000_0000);
      send_request(KIND_BAD, 32'd0);
      send_request(KIND_BAD, 32'hFFFF_FFFF);
      hold_idle(12);

      run_phase(80, 0);
      run_phase(80, 85);
      run_phase(80, 30);
      run_phase(60, 0);

      @(negedge clock);
      start = 1'b0;
      while (sb.pending_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending_chars.size() != 0) begin
         $display("%0t: %0d expected chars never arrived", $realtime, sb.pending_chars.size());
         sb.errors++;
      end
      $display("Covered %0d requests (signed %0d, unsigned %0d, hex %0d, unused kind %0d)",
               sb.requests_noted, sb.kind_count[KIND_SDEC], sb.kind_count[KIND_UDEC],
               sb.kind_count[KIND_HEX], sb.kind_count[KIND_BAD]);
      $display("Checked %0d output chars in %0d cycles, %0d errors", sb.chars_checked, cycles,
               sb.errors);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== integer_to_ascii_formatter.f =====
design/i2a_pkg.sv
design/i2a_dabble.sv
design/i2a_emit.sv
design/integer_to_ascii_formatter.sv
design/i2a_checker.sv
tb/integer_to_ascii_formatter_test.sv
